// ----- rtl/core/bbcd_pkg.sv -----
// Shared types and codes for the block buffer cache directory.
package bbcd_pkg;

    // Command codes (s_tuser)
    localparam logic [1:0] CMD_GET     = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_PIN     = 2'd2;
    localparam logic [1:0] CMD_UNPIN   = 2'd3;

    // Result status codes (m_tuser)
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFREE = 2'd1;
    localparam logic [1:0] ST_UNDER  = 2'd2;
    localparam logic [1:0] ST_OVER   = 2'd3;

    localparam int          COUNT_W   = 8;
    localparam logic [7:0]  COUNT_MAX = 8'hFF;

    // One directory entry as stored in the memory
    typedef struct packed {
        logic               tag_valid;
        logic [15:0]        device;
        logic [31:0]        block;
        logic [COUNT_W-1:0] count;
        logic [31:0]        stamp;
        logic               data_valid;
    } entry_t;

endpackage

// ----- rtl/core/bbcd_dir_mem.sv -----
// Directory memory: one entry per buffer slot, registered read, per-entry valid bits.
module bbcd_dir_mem #(
    parameter int NUM_BUFFERS = 32,
    parameter int IDX_W       = $clog2(NUM_BUFFERS)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_en,
    input  logic [IDX_W-1:0]    rd_addr,
    output bbcd_pkg::entry_t    rd_entry,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_addr,
    input  bbcd_pkg::entry_t    wr_entry
);
    import bbcd_pkg::*;

    entry_t                 mem [NUM_BUFFERS];
    logic [NUM_BUFFERS-1:0] written_reg;
    entry_t                 rd_data_reg;
    logic                   rd_ok_reg;

    // Storage array, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Written flags: an entry never written reads as all zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            rd_ok_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_ok_reg <= written_reg[rd_addr];
            end
        end
    end

    assign rd_entry = rd_ok_reg ? rd_data_reg : '0;

endmodule

// ----- rtl/core/block_buffer_cache_directory_top.sv -----
// Top level of the block buffer cache directory.
//
// Usage:
//   Slave channel s_*: one request word per transfer. s_tuser holds the
//   command (get, release, pin, unpin); s_tdata holds device, block number,
//   slot and current tick. Master channel m_*: one result word per request,
//   m_tdata holds result slot, hit and needs_read, m_tuser holds the status.
//   Requests are processed one at a time. A get scans every directory entry
//   through the single memory read port. Release, pin and unpin read and
//   write back one entry; a slot out of range answers without a read.
//   The result sits in an output register; the next request is accepted
//   while it waits, and finishes into that register once the receiver
//   takes the previous word. A stalled receiver holds m_tdata and m_tuser.
//   Reset (rst_n, asynchronous) empties the directory at once: every entry
//   reads as untagged with count and stamp zero; no clearing pass is needed.
module block_buffer_cache_directory_top #(
    parameter int NUM_BUFFERS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // request: tuser = command[1:0]
    // tdata  = device[15:0], block_number[47:16], slot[52:48],
    //          current_tick[84:53], zero pad[87:85]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,
    input  logic [1:0]  s_tuser,
    // result: tdata = result_slot[4:0], hit[5], needs_read[6], zero pad[7]
    // tuser  = status[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    output logic [1:0]  m_tuser
);
    import bbcd_pkg::*;

    localparam int IDX_W = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
    localparam int CNT_W = $clog2(NUM_BUFFERS + 1);
    localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(NUM_BUFFERS);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_DECIDE  = 3'd2;
    localparam logic [2:0] S_SLOT_RD = 3'd3;
    localparam logic [2:0] S_SLOT_WB = 3'd4;
    localparam logic [2:0] S_FINISH  = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic             chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0] chk_idx_reg, chk_idx_next;
    logic [1:0]       cmd_reg, cmd_next;
    logic [15:0]      dev_reg, dev_next;
    logic [31:0]      blk_reg, blk_next;
    logic [4:0]       slot_reg, slot_next;
    logic [31:0]      tick_reg, tick_next;
    logic             hit_found_reg, hit_found_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    entry_t           hit_ent_reg, hit_ent_next;
    logic             have_reg, have_next;
    logic [IDX_W-1:0] vic_idx_reg, vic_idx_next;
    logic [31:0]      vic_stamp_reg, vic_stamp_next;
    logic [4:0]       res_slot_reg, res_slot_next;
    logic             res_hit_reg, res_hit_next;
    logic             res_nread_reg, res_nread_next;
    logic [1:0]       res_status_reg, res_status_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_data_reg, out_data_next;
    logic [1:0]       out_user_reg, out_user_next;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    entry_t           rd_entry;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_entry;

    logic             in_fire;
    logic             out_free;
    logic             ent_match;
    logic             ent_better;

    bbcd_dir_mem #(
        .NUM_BUFFERS (NUM_BUFFERS),
        .IDX_W       (IDX_W)
    ) u_dir_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_entry (wr_entry)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // Per-entry scan checks on the word just read
    assign ent_match  = rd_entry.tag_valid && (rd_entry.device == dev_reg) &&
                        (rd_entry.block == blk_reg);
    assign ent_better = (rd_entry.count == '0) &&
                        (!have_reg || (rd_entry.stamp < vic_stamp_reg));

    // Sequencer and datapath
    always_comb
    begin
        state_next      = state_reg;
        scan_cnt_next   = scan_cnt_reg;
        chk_valid_next  = 1'b0;
        chk_idx_next    = chk_idx_reg;
        cmd_next        = cmd_reg;
        dev_next        = dev_reg;
        blk_next        = blk_reg;
        slot_next       = slot_reg;
        tick_next       = tick_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_ent_next    = hit_ent_reg;
        have_next       = have_reg;
        vic_idx_next    = vic_idx_reg;
        vic_stamp_next  = vic_stamp_reg;
        res_slot_next   = res_slot_reg;
        res_hit_next    = res_hit_reg;
        res_nread_next  = res_nread_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_user_next   = out_user_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_entry        = '0;

        // receiver takes the waiting word
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_next        = s_tuser;
                    dev_next        = s_tdata[15:0];
                    blk_next        = s_tdata[47:16];
                    slot_next       = s_tdata[52:48];
                    tick_next       = s_tdata[84:53];
                    scan_cnt_next   = '0;
                    hit_found_next  = 1'b0;
                    have_next       = 1'b0;
                    res_slot_next   = s_tdata[52:48];
                    res_hit_next    = 1'b0;
                    res_nread_next  = 1'b0;
                    res_status_next = ST_OK;
                    if (s_tuser == CMD_GET)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (32'(s_tdata[52:48]) < NUM_BUFFERS)
                    begin
                        state_next = S_SLOT_RD;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end

            S_SCAN:
            begin
                // issue the next read
                if (scan_cnt_reg < SCAN_END)
                begin
                    rd_en          = 1'b1;
                    rd_addr        = scan_cnt_reg[IDX_W-1:0];
                    chk_valid_next = 1'b1;
                    chk_idx_next   = scan_cnt_reg[IDX_W-1:0];
                    scan_cnt_next  = scan_cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = S_DECIDE;
                end
                // evaluate the word read last cycle; ascending order keeps
                // the lowest slot on a match or a stamp tie
                if (chk_valid_reg)
                begin
                    if (ent_match && !hit_found_reg)
                    begin
                        hit_found_next = 1'b1;
                        hit_idx_next   = chk_idx_reg;
                        hit_ent_next   = rd_entry;
                    end
                    if (ent_better)
                    begin
                        have_next      = 1'b1;
                        vic_idx_next   = chk_idx_reg;
                        vic_stamp_next = rd_entry.stamp;
                    end
                end
            end

            S_DECIDE:
            begin
                state_next = S_FINISH;
                if (hit_found_reg)
                begin
                    wr_en               = 1'b1;
                    wr_addr             = hit_idx_reg;
                    wr_entry            = hit_ent_reg;
                    wr_entry.data_valid = 1'b1;
                    res_slot_next       = 5'(hit_idx_reg);
                    res_hit_next        = 1'b1;
                    res_nread_next      = !hit_ent_reg.data_valid;
                    if (hit_ent_reg.count == COUNT_MAX)
                    begin
                        res_status_next = ST_OVER;
                    end
                    else
                    begin
                        wr_entry.count = hit_ent_reg.count + 1'b1;
                    end
                end
                else if (have_reg)
                begin
                    // retag the victim; its data is stale, so a read is due
                    wr_en               = 1'b1;
                    wr_addr             = vic_idx_reg;
                    wr_entry.tag_valid  = 1'b1;
                    wr_entry.device     = dev_reg;
                    wr_entry.block      = blk_reg;
                    wr_entry.count      = COUNT_W'(1);
                    wr_entry.stamp      = vic_stamp_reg;
                    wr_entry.data_valid = 1'b1;
                    res_slot_next       = 5'(vic_idx_reg);
                    res_nread_next      = 1'b1;
                end
                else
                begin
                    res_slot_next   = '0;
                    res_status_next = ST_NOFREE;
                end
            end

            S_SLOT_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = IDX_W'(slot_reg);
                state_next = S_SLOT_WB;
            end

            S_SLOT_WB:
            begin
                wr_en      = 1'b1;
                wr_addr    = IDX_W'(slot_reg);
                wr_entry   = rd_entry;
                state_next = S_FINISH;
                if (cmd_reg == CMD_PIN)
                begin
                    if (rd_entry.count == COUNT_MAX)
                    begin
                        res_status_next = ST_OVER;
                    end
                    else
                    begin
                        wr_entry.count = rd_entry.count + 1'b1;
                    end
                end
                else
                begin
                    if (rd_entry.count == '0)
                    begin
                        res_status_next = ST_UNDER;
                    end
                    else
                    begin
                        wr_entry.count = rd_entry.count - 1'b1;
                    end
                    if (cmd_reg == CMD_RELEASE)
                    begin
                        wr_entry.stamp = tick_reg;
                    end
                end
            end

            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {1'b0, res_nread_reg, res_hit_reg, res_slot_reg};
                    out_user_next  = res_status_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chk_valid_reg <= chk_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        scan_cnt_reg   <= scan_cnt_next;
        chk_idx_reg    <= chk_idx_next;
        cmd_reg        <= cmd_next;
        dev_reg        <= dev_next;
        blk_reg        <= blk_next;
        slot_reg       <= slot_next;
        tick_reg       <= tick_next;
        hit_found_reg  <= hit_found_next;
        hit_idx_reg    <= hit_idx_next;
        hit_ent_reg    <= hit_ent_next;
        have_reg       <= have_next;
        vic_idx_reg    <= vic_idx_next;
        vic_stamp_reg  <= vic_stamp_next;
        res_slot_reg   <= res_slot_next;
        res_hit_reg    <= res_hit_next;
        res_nread_reg  <= res_nread_next;
        res_status_reg <= res_status_next;
        out_data_reg   <= out_data_next;
        out_user_reg   <= out_user_next;
    end

    // Checks
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (scan_cnt_reg <= SCAN_END))
        else $error("scan counter ran past the directory");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_tready)
        else $error("request accepted while another is in progress");

    a_nofree_word: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == ST_NOFREE)) |-> (m_tdata == 8'd0))
        else $error("no-free result carries a slot or flags");

    a_hit_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[5]) |-> !m_tdata[6])
        else $error("hit on an entry whose data was never marked valid");

    a_single_writer: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !rd_en)
        else $error("directory read and write in the same cycle");

endmodule
